// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants of the LRU page replacement core.
// ----------------------------------------------------------------------------
package lpr_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;
    localparam int AGE_BITS_DEF   = 16;

    // Fixed field widths of the stream and register interfaces
    localparam int PAGE_IN_W  = 16;
    localparam int FRAME_IX_W = 4;
    localparam int EVICT_PG_W = 16;
    localparam int FAULT_W    = 32;
    localparam int FIU_W      = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

    // One result transaction
    typedef struct packed {
        logic [FAULT_W-1:0]    fault_count;
        logic [EVICT_PG_W-1:0] evicted_page;
        logic                  evicted_valid;
        logic [FRAME_IX_W-1:0] frame_index;
        logic                  hit;
    } lpr_result_t;

endpackage

// ===== sv/lru_page_replacement_core.sv =====
// Path from input transaction to result valid: sweep state, finish state, then
// the output register. A new reference is accepted only in the idle state; the
// sweep over the frame table through its single read port sets the pace.
// A finished result waits in the output register; the next reference runs meanwhile.
// Reset (rst_n, async, low): no frames filled, all ages zero, fault total zero,
// frames_in_use = 16. No clearing pass; ages of unwritten frames read as zero.
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// LRU page replacement with per-frame saturating age counters.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
    parameter int NUM_FRAMES = lpr_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF,
    parameter int AGE_BITS   = lpr_pkg::AGE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // reference stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,   // [15:0] page_number
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] hit, [4:1] frame_index, [5] evicted_valid, [21:6] evicted_page,
    // [53:22] fault_count, [55:54] zero
    output logic [55:0]                    m_axis_tdata,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lpr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lpr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import lpr_pkg::*;

    localparam int IDX_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int WORD_W = PAGE_BITS + AGE_BITS;

    logic [FIU_W-1:0]  frames_in_use;
    lpr_result_t       result;

    // Frame table port signals; each word is {page, age}
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [WORD_W-1:0] mem_rd_data;
    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;

    lpr_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .frames_in_use (frames_in_use)
    );

    lpr_frame_mem #(
        .DEPTH  (NUM_FRAMES),
        .ADDR_W (IDX_W),
        .WIDTH  (WORD_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Per reference: read every frame once (age it, look for the page, track
    // the oldest among active frames), then one write of the chosen frame.
    lpr_engine #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .AGE_BITS   (AGE_BITS),
        .IDX_W      (IDX_W)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_page       (s_axis_tdata),
        .frames_in_use (frames_in_use),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_data      (result),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data)
    );

    // Result fields packed from bit 0 up, zero fill to a byte boundary
    assign m_axis_tdata = {2'b00, result.fault_count, result.evicted_page,
                           result.evicted_valid, result.frame_index, result.hit};

endmodule

// ===== sv/lpr_frame_mem.sv =====
// ----------------------------------------------------------------------------
// lpr_frame_mem
// Frame table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpr_frame_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int WIDTH  = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/lpr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lpr_cfg_regs
// APB register slave holding the frames_in_use register.
// ----------------------------------------------------------------------------
module lpr_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lpr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lpr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    output logic [lpr_pkg::FIU_W-1:0]      frames_in_use
);
    import lpr_pkg::*;

    // Register index is the word address (paddr[2])
    localparam logic REG_FRAMES_IN_USE = 1'b0;

    logic [FIU_W-1:0] fiu_reg;
    logic             wr_fire;
    logic             sel_fiu;

    assign pready  = 1'b1;
    assign sel_fiu = (paddr[2] == REG_FRAMES_IN_USE);
    assign wr_fire = psel && penable && pwrite && pready && sel_fiu;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg <= FIU_RESET;
        end
        else if (wr_fire)
        begin
            fiu_reg <= pwdata[FIU_W-1:0];
        end
    end

    assign prdata        = sel_fiu ? CFG_DATA_W'(fiu_reg) : '0;
    assign frames_in_use = fiu_reg;

endmodule

// ===== sv/lpr_engine.sv =====
// ----------------------------------------------------------------------------
// lpr_engine
// Sweep sequencer: reads every frame, ages it, searches hit and oldest,
// then writes the chosen frame and loads the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpr_engine #(
    parameter int NUM_FRAMES = lpr_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF,
    parameter int AGE_BITS   = lpr_pkg::AGE_BITS_DEF,
    parameter int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // reference stream
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lpr_pkg::PAGE_IN_W-1:0]  in_page,
    input  logic [lpr_pkg::FIU_W-1:0]      frames_in_use,
    // result stream
    output logic                           out_valid,
    input  logic                           out_ready,
    output lpr_pkg::lpr_result_t           out_data,
    // frame table
    output logic                           mem_rd_en,
    output logic [IDX_W-1:0]               mem_rd_addr,
    input  logic [PAGE_BITS+AGE_BITS-1:0]  mem_rd_data,
    output logic                           mem_wr_en,
    output logic [IDX_W-1:0]               mem_wr_addr,
    output logic [PAGE_BITS+AGE_BITS-1:0]  mem_wr_data
);
    import lpr_pkg::*;

    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam logic [CNT_W-1:0]    NUM_CNT = CNT_W'(NUM_FRAMES);
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     rd_cnt_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     ridx_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     used_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [AGE_BITS-1:0]  best_age_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [PAGE_BITS-1:0] best_page_reg;
    logic [CNT_W-1:0]     filled_reg;
    logic [FAULT_W-1:0]   faults_reg;
    logic [NUM_FRAMES-1:0] valid_reg;
    logic                 out_valid_reg;
    lpr_result_t          out_data_reg;

    logic [31:0]          fiu32;
    logic [31:0]          page32;
    logic [CNT_W-1:0]     n_calc;
    logic [CNT_W-1:0]     used_calc;
    logic                 accept;
    logic                 fire;
    logic [PAGE_BITS-1:0] rd_page;
    logic [AGE_BITS-1:0]  rd_age;
    logic [AGE_BITS-1:0]  aged;
    logic [CNT_W-1:0]     ridx_ext;
    logic                 match;
    logic                 take_best;
    logic                 has_free;
    logic [IDX_W-1:0]     slot;
    logic [FAULT_W-1:0]   faults_next;
    logic [31:0]          slot32;
    logic [31:0]          old32;
    lpr_result_t          result;

    // Effective frame count: zero acts as one, clamp to table depth
    assign fiu32 = 32'(frames_in_use);
    always_comb
    begin
        if (fiu32 == 32'd0)
        begin
            n_calc = CNT_W'(1);
        end
        else if (fiu32 > 32'(NUM_FRAMES))
        begin
            n_calc = NUM_CNT;
        end
        else
        begin
            n_calc = fiu32[CNT_W-1:0];
        end
    end
    assign used_calc = (filled_reg < n_calc) ? filled_reg : n_calc;
    assign page32    = 32'(in_page);

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign fire     = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // Read side of the sweep
    assign mem_rd_en   = (state_reg == ST_SWEEP) && (rd_cnt_reg < NUM_CNT);
    assign mem_rd_addr = rd_cnt_reg[IDX_W-1:0];

    // Entry returned by the memory this cycle
    assign rd_page   = mem_rd_data[PAGE_BITS+AGE_BITS-1:AGE_BITS];
    assign rd_age    = valid_reg[ridx_reg] ? mem_rd_data[AGE_BITS-1:0] : '0;
    assign aged      = (rd_age == AGE_MAX) ? rd_age : rd_age + 1'b1;
    assign ridx_ext  = CNT_W'(ridx_reg);
    assign match     = (ridx_ext < used_reg) && (rd_page == page_reg);
    assign take_best = (ridx_ext < n_reg) && ((ridx_reg == '0) || (aged > best_age_reg));

    // Replacement decision
    assign has_free    = (filled_reg < n_reg);
    assign faults_next = (faults_reg == '1) ? faults_reg : faults_reg + 1'b1;
    always_comb
    begin
        if (hit_reg)
        begin
            slot = hit_idx_reg;
        end
        else if (has_free)
        begin
            slot = filled_reg[IDX_W-1:0];
        end
        else
        begin
            slot = best_idx_reg;
        end
    end

    assign slot32 = 32'(slot);
    assign old32  = (!hit_reg && !has_free) ? 32'(best_page_reg) : 32'd0;
    always_comb
    begin
        result.hit           = hit_reg;
        result.frame_index   = slot32[FRAME_IX_W-1:0];
        result.evicted_valid = !hit_reg && !has_free;
        result.evicted_page  = old32[EVICT_PG_W-1:0];
        result.fault_count   = hit_reg ? faults_reg : faults_next;
    end

    // Write port: aged write-back during the sweep, chosen frame at the end
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = ridx_reg;
        mem_wr_data = {rd_page, aged};
        if (fire)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot;
            mem_wr_data = {page_reg, {AGE_BITS{1'b0}}};
        end
        else if (pend_reg)
        begin
            mem_wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if ((rd_cnt_reg == NUM_CNT) && pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            filled_reg    <= '0;
            faults_reg    <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= mem_rd_en;
            if (accept)
            begin
                rd_cnt_reg <= '0;
                hit_reg    <= 1'b0;
            end
            else if (mem_rd_en)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            if (pend_reg && match && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (mem_wr_en)
            begin
                valid_reg[mem_wr_addr] <= 1'b1;
            end
            if (fire)
            begin
                if (!hit_reg)
                begin
                    faults_reg <= faults_next;
                    if (has_free)
                    begin
                        filled_reg <= filled_reg + 1'b1;
                    end
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and search registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= page32[PAGE_BITS-1:0];
            n_reg    <= n_calc;
            used_reg <= used_calc;
        end
        if (mem_rd_en)
        begin
            ridx_reg <= mem_rd_addr;
        end
        if (pend_reg && match && !hit_reg)
        begin
            hit_idx_reg <= ridx_reg;
        end
        if (pend_reg && take_best)
        begin
            best_age_reg  <= aged;
            best_idx_reg  <= ridx_reg;
            best_page_reg <= rd_page;
        end
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_IMPL(a_filled_bound, 1'b1, filled_reg <= NUM_CNT, "filled frame count past depth")
    `ASSERT_IMPL(a_pend_in_sweep, pend_reg, state_reg == ST_SWEEP, "read return outside sweep")
    `ASSERT_NEXT(a_faults_mono, 1'b1, faults_reg >= $past(faults_reg), "fault total decreased")
    `ASSERT_IMPL(a_hit_no_evict, out_valid_reg && out_data_reg.hit, !out_data_reg.evicted_valid,
        "hit reported with eviction")

endmodule
